/* design/tbn_pkg.sv */
// ----------------------------------------------------------------------------
// tbn_pkg: shared types and constants for the timestamp table
// Table sizing, request codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbn_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = IDX_W + 1;
    localparam int FRACTION_BITS = 16;
    localparam int FRAC_CNT_W    = $clog2(FRACTION_BITS + 1);
    localparam int STAMP_W       = 64;
    localparam int INDEX_OUT_W   = 11;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_SORT   = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_OUTER,
        ST_SORT_RDV,
        ST_SORT_LDV,
        ST_SORT_RDJ,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_BS_RD,
        ST_BS_CMP,
        ST_BR_RD0,
        ST_BR_CMP0,
        ST_BR_RD1,
        ST_BR_CMP1,
        ST_DIV,
        ST_NEAR,
        ST_OUT
    } state_t;

endpackage

/* design/timestamp_bracket_nearest_table.sv */
// ----------------------------------------------------------------------------
// timestamp_bracket_nearest_table
// Timestamp table with append, in-place insertion sort and a query that
// returns exact index, lower-bound bracket with Q0.16 fraction, and nearest.
// ----------------------------------------------------------------------------
// Query steps: linear exact scan, binary search, then division at one
//   quotient bit per cycle; sort is an in-place insertion sort. All table
//   traffic goes through one write port and one registered read port.
// Throughput: one request at a time; s_tready is high only in idle with no
//   result waiting.
// Reset: entry count and control cleared; table contents left undefined.
`timescale 1ns / 1ps

module timestamp_bracket_nearest_table
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [1:0] action, [65:2] query_stamp
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata    // status, frame_index[11], lower_stamp,
                                    // upper_stamp, bracket_valid, fraction[16],
                                    // nearest_stamp, nearest_delta
);
    import tbn_pkg::*;

    // table with one write port and one registered read port
    logic [STAMP_W-1:0] mem [TABLE_DEPTH];
    logic [STAMP_W-1:0] rd_data;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    logic [STAMP_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [STAMP_W-1:0] q_reg;
    logic [CNT_W-1:0]   i_reg, i_next;       // sort outer / scan index
    logic [CNT_W-1:0]   j_reg, j_next;       // sort inner index
    logic [STAMP_W-1:0] v_reg;               // sort key
    logic [CNT_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic               found_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [STAMP_W-1:0] lower_reg, upper_reg;
    logic               valid_reg;
    logic [STAMP_W-1:0] rem_reg, den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [FRAC_CNT_W-1:0]    dcnt_reg;
    logic [STAMP_W-1:0] near_reg;
    logic               status_reg;
    logic               out_valid_reg;
    logic [287:0]       out_data_reg;
    logic [1:0]         q_action_reg;        // request kind held for formatting

    logic [CNT_W-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // subtract/compare unit for division
    logic [STAMP_W:0]   shl;
    logic [STAMP_W:0]   sub;
    assign shl = {rem_reg, 1'b0};
    assign sub = shl - {1'b0, den_reg};

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    unique case (action_t'(s_tdata[1:0]))
                        ACT_SORT:
                        begin
                            state_next = ST_SORT_OUTER;
                            i_next     = CNT_W'(1);
                        end
                        ACT_QUERY:
                        begin
                            state_next = ST_SCAN_RD;
                            i_next     = '0;
                            lo_next    = '0;
                            hi_next    = count_reg;
                        end
                        ACT_APPEND, ACT_NONE: state_next = ST_OUT;
                    endcase
                end
            end
            ST_SORT_OUTER:
                state_next = (i_reg < count_reg) ? ST_SORT_RDV : ST_OUT;
            ST_SORT_RDV: state_next = ST_SORT_LDV;
            ST_SORT_LDV:
            begin
                j_next     = i_reg;
                state_next = ST_SORT_RDJ;
            end
            ST_SORT_RDJ:
                state_next = (j_reg == '0) ? ST_SORT_PUT : ST_SORT_CMP;
            ST_SORT_CMP:
            begin
                if (rd_data > v_reg)
                begin
                    j_next     = j_reg - CNT_W'(1);
                    state_next = ST_SORT_RDJ;
                end
                else
                begin
                    state_next = ST_SORT_PUT;
                end
            end
            ST_SORT_PUT:
            begin
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_SORT_OUTER;
            end
            ST_SCAN_RD:
                state_next = (i_reg < count_reg) ? ST_SCAN_CMP :
                             ((count_reg == '0) ? ST_NEAR : ST_BS_RD);
            ST_SCAN_CMP:
            begin
                if (rd_data == q_reg)
                begin
                    state_next = ST_BS_RD;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_BS_RD:
                state_next = (lo_reg < hi_reg) ? ST_BS_CMP : ST_BR_RD0;
            ST_BS_CMP:
            begin
                if (rd_data < q_reg)
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_BS_RD;
            end
            ST_BR_RD0:
                state_next = ST_BR_CMP0;
            ST_BR_CMP0:
                state_next = (lo_reg >= count_reg || lo_reg == '0 || rd_data == q_reg)
                             ? ST_NEAR : ST_BR_RD1;
            ST_BR_RD1: state_next = ST_BR_CMP1;
            ST_BR_CMP1: state_next = ST_DIV;
            ST_DIV:
                state_next = (dcnt_reg == FRAC_CNT_W'(FRACTION_BITS - 1)) ? ST_NEAR : ST_DIV;
            ST_NEAR: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = v_reg;
        mem_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we    = s_tvalid && s_tready &&
                            (action_t'(s_tdata[1:0]) == ACT_APPEND) &&
                            (count_reg < CNT_W'(TABLE_DEPTH));
                mem_waddr = count_reg[IDX_W-1:0];
                mem_wdata = s_tdata[65:2];
            end
            ST_SORT_RDV: mem_raddr = i_reg[IDX_W-1:0];
            ST_SORT_RDJ: mem_raddr = j_reg[IDX_W-1:0] - IDX_W'(1);
            ST_SORT_CMP:
            begin
                mem_we    = rd_data > v_reg;
                mem_waddr = j_reg[IDX_W-1:0];
                mem_wdata = rd_data;
            end
            ST_SORT_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
            end
            ST_SCAN_RD: mem_raddr = i_reg[IDX_W-1:0];
            ST_BS_RD:   mem_raddr = mid[IDX_W-1:0];
            ST_BR_RD0:  mem_raddr = (lo_reg >= count_reg) ?
                                    IDX_W'(count_reg - CNT_W'(1)) : lo_reg[IDX_W-1:0];
            ST_BR_RD1:  mem_raddr = IDX_W'(lo_reg - CNT_W'(1));
            default:    mem_raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we && state_reg == ST_IDLE)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        i_reg  <= i_next;
        j_reg  <= j_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_reg      <= s_tdata[65:2];
                found_reg  <= 1'b0;
                pos_reg    <= '0;
                lower_reg  <= '0;
                upper_reg  <= '0;
                valid_reg  <= 1'b0;
                quo_reg    <= '0;
                dcnt_reg   <= '0;
                near_reg   <= '0;
                status_reg <= (action_t'(s_tdata[1:0]) == ACT_APPEND) &&
                              (count_reg >= CNT_W'(TABLE_DEPTH));
            end
            ST_SORT_LDV: v_reg <= rd_data;
            ST_SCAN_CMP:
            begin
                if (rd_data == q_reg)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= i_reg;
                end
            end
            ST_BR_CMP0:
            begin
                if (lo_reg >= count_reg)
                begin
                    lower_reg <= rd_data;
                end
                else if (lo_reg == '0)
                begin
                    upper_reg <= rd_data;
                end
                else if (rd_data == q_reg)
                begin
                    lower_reg <= q_reg;
                    upper_reg <= q_reg;
                    valid_reg <= 1'b1;
                end
                else
                begin
                    upper_reg <= rd_data;
                    valid_reg <= 1'b1;
                end
            end
            ST_BR_CMP1:
            begin
                lower_reg <= rd_data;
                rem_reg   <= q_reg - rd_data;
                den_reg   <= upper_reg - rd_data;
            end
            ST_DIV:
            begin
                dcnt_reg <= dcnt_reg + FRAC_CNT_W'(1);
                if (!sub[STAMP_W] || shl[STAMP_W])
                begin
                    rem_reg <= sub[STAMP_W-1:0];
                    quo_reg <= {quo_reg[FRACTION_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shl[STAMP_W-1:0];
                    quo_reg <= {quo_reg[FRACTION_BITS-2:0], 1'b0};
                end
            end
            ST_NEAR:
            begin
                if (!valid_reg)
                begin
                    near_reg <= (lower_reg != '0) ? lower_reg : upper_reg;
                end
                else if ((q_reg - lower_reg) <= (upper_reg - q_reg))
                begin
                    near_reg <= lower_reg;
                end
                else
                begin
                    near_reg <= upper_reg;
                end
            end
            ST_OUT:
            begin
                if (action_t'(q_action_reg) == ACT_QUERY)
                begin
                    out_data_reg <= {
                        3'b000,
                        (near_reg != '0) ? (q_reg - near_reg) : {STAMP_W{1'b0}},
                        near_reg,
                        quo_reg,
                        valid_reg,
                        upper_reg,
                        lower_reg,
                        found_reg ? pos_reg[INDEX_OUT_W-1:0] : {INDEX_OUT_W{1'b1}},
                        status_reg
                    };
                end
                else
                begin
                    out_data_reg <= {287'b0, status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            q_action_reg <= s_tdata[1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_bs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BS_CMP) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search bounds broken");

endmodule
